// ----- sv/kpe_pkg.sv -----
// Shared types, constants and key codes for the keypad PIN entry block.
package kpe_pkg;

	localparam int NUM_KEYS   = 12;
	localparam int PIN_LENGTH = 4;
	localparam int KEY_W      = 4;

	localparam logic [KEY_W-1:0] KEY_ZERO  = 4'd9;
	localparam logic [KEY_W-1:0] KEY_ENTER = 4'd10;
	localparam logic [KEY_W-1:0] KEY_CLEAR = 4'd11;
	localparam logic [KEY_W-1:0] KEY_LAST  = KEY_W'(NUM_KEYS - 1);

	localparam logic [3:0] EMPTY_SLOT = 4'hF;

	typedef enum logic [2:0] {
		ACT_IGNORED   = 3'd0,
		ACT_STORED    = 3'd1,
		ACT_CLEARED   = 3'd2,
		ACT_TOO_FEW   = 3'd3,
		ACT_TOO_MANY  = 3'd4,
		ACT_SUBMITTED = 3'd5
	} action_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch a scan, restart the key walk
		logic advance;   // move to the next key
		logic emit;      // handle current key, load the output register
	} kpe_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic new_press; // current key has a rising edge
		logic last_key;  // walk is at the final key
		logic out_free;  // output register can take a result this cycle
	} kpe_stat_t;

endpackage

// ----- sv/keypad_pin_entry.sv -----
// A scan is taken in idle; the walk then visits the 12 keys in turn, and a newly pressed key's result
// loads the output register. No new scan is taken until the walk ends, and the walk holds on a pressed
// key until the output register has room, so an output stall lengthens the walk.
// Reset (arst_n low, asynchronous): no keys held, ready mode, PIN buffer empty (all slots 15),
// no result pending.
module keypad_pin_entry #(
	parameter int PinLength = kpe_pkg::PIN_LENGTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// scan input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [kpe_pkg::NUM_KEYS-1:0] key_levels,
	input  logic                         entry_blocked,
	// result output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [3:0]                   key_index,
	output logic [2:0]                   action,
	output logic                         entered_entry_mode,
	output logic [15:0]                  pin_digits,
	output logic [2:0]                   digit_count,
	output logic [1:0]                   beep_count,
	output logic                         last_of_scan
);

	// The controller only sequences: take a scan in idle, then walk every key.
	// The datapath finds rising edges at capture time (held mask becomes the
	// scan's levels at once), and each newly pressed key produces one transfer
	// through a single output register. A new scan can be taken while the last
	// result still waits in that register.
	kpe_pkg::kpe_cmd_t  cmd;
	kpe_pkg::kpe_stat_t stat;

	kpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	kpe_dp #(
		.PinLength (PinLength)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.key_levels         (key_levels),
		.entry_blocked      (entry_blocked),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.key_index          (key_index),
		.action             (action),
		.entered_entry_mode (entered_entry_mode),
		.pin_digits         (pin_digits),
		.digit_count        (digit_count),
		.beep_count         (beep_count),
		.last_of_scan       (last_of_scan)
	);

endmodule

// ----- sv/kpe_ctrl.sv -----
// Controller state machine: accepts scans and sequences the key walk.
module kpe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  kpe_pkg::kpe_stat_t  stat,
	output kpe_pkg::kpe_cmd_t   cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
			end
			ST_WALK: begin
				// a pressed key waits for room in the output register
				cmd.emit    = stat.new_press && stat.out_free;
				cmd.advance = !stat.new_press || stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (cmd.advance && stat.last_key) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/kpe_dp.sv -----
// Datapath: key edge capture, key walk index, PIN buffer and output register.
module kpe_dp #(
	parameter int PinLength = kpe_pkg::PIN_LENGTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kpe_pkg::kpe_cmd_t                 cmd,
	output kpe_pkg::kpe_stat_t                stat,
	input  logic [kpe_pkg::NUM_KEYS-1:0]      key_levels,
	input  logic                              entry_blocked,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [3:0]                        key_index,
	output logic [2:0]                        action,
	output logic                              entered_entry_mode,
	output logic [15:0]                       pin_digits,
	output logic [2:0]                        digit_count,
	output logic [1:0]                        beep_count,
	output logic                              last_of_scan
);

	localparam int CntW  = $clog2(PinLength + 1);
	localparam int NShow = (PinLength < 4) ? PinLength : 4;
	localparam int NK    = kpe_pkg::NUM_KEYS;

	logic [NK-1:0]               held_q;
	logic [NK-1:0]               press_q;
	logic                        blocked_q;
	logic [kpe_pkg::KEY_W-1:0]   key_q;
	logic                        entry_mode_q;
	logic [CntW-1:0]             cnt_q;
	logic [3:0]                  buf_q [PinLength];
	logic                        out_valid_q;

	logic [3:0]                  buf_n [PinLength];
	logic [CntW-1:0]             cnt_n;
	logic                        full;
	logic                        do_store;
	logic                        do_clear;
	logic [3:0]                  digit;
	kpe_pkg::action_t            act;
	logic [1:0]                  beeps;
	logic                        entered;
	logic [15:0]                 pin;
	logic [CntW-1:0]             cnt_out;
	logic [3:0]                  cnt_x;
	logic [NK-1:0]               later;

	assign stat.new_press = press_q[key_q];
	assign stat.last_key  = (key_q == kpe_pkg::KEY_LAST);
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign full  = (cnt_q >= CntW'(PinLength));
	assign digit = (key_q == kpe_pkg::KEY_ZERO) ? 4'd0 : 4'(key_q + 4'd1);
	assign later = (press_q >> key_q) >> 1;

	// per-key decision
	always_comb begin
		act      = kpe_pkg::ACT_IGNORED;
		beeps    = 2'd0;
		entered  = 1'b0;
		do_store = 1'b0;
		do_clear = 1'b0;
		if (!blocked_q) begin
			entered = !entry_mode_q;
			beeps   = 2'd1;
			if (key_q == kpe_pkg::KEY_CLEAR) begin
				act      = kpe_pkg::ACT_CLEARED;
				do_clear = 1'b1;
			end else if (key_q == kpe_pkg::KEY_ENTER) begin
				act = full ? kpe_pkg::ACT_SUBMITTED : kpe_pkg::ACT_TOO_FEW;
			end else if (full) begin
				act   = kpe_pkg::ACT_TOO_MANY;
				beeps = 2'd2;
			end else begin
				act      = kpe_pkg::ACT_STORED;
				do_store = 1'b1;
			end
		end
	end

	// buffer after the key, before a submit empties it
	always_comb begin
		for (int s = 0; s < PinLength; s++) begin
			if (do_clear) begin
				buf_n[s] = kpe_pkg::EMPTY_SLOT;
			end else if (do_store && (cnt_q == CntW'(s))) begin
				buf_n[s] = digit;
			end else begin
				buf_n[s] = buf_q[s];
			end
		end
		if (do_clear) begin
			cnt_n = '0;
		end else if (do_store) begin
			cnt_n = cnt_q + CntW'(1);
		end else begin
			cnt_n = cnt_q;
		end
		pin = 16'hFFFF;
		for (int s = 0; s < NShow; s++) begin
			pin[4*s +: 4] = buf_n[s];
		end
		cnt_out = (act == kpe_pkg::ACT_SUBMITTED) ? '0 : cnt_n;
		cnt_x   = 4'(cnt_out);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			press_q      <= '0;
			blocked_q    <= 1'b0;
			key_q        <= '0;
			entry_mode_q <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			for (int s = 0; s < PinLength; s++) begin
				buf_q[s] <= kpe_pkg::EMPTY_SLOT;
			end
		end else begin
			if (cmd.capture) begin
				press_q   <= key_levels & ~held_q;
				held_q    <= key_levels;
				blocked_q <= entry_blocked;
				key_q     <= '0;
			end else if (cmd.advance && !stat.last_key) begin
				key_q <= key_q + 4'd1;
			end
			if (cmd.emit) begin
				if (act == kpe_pkg::ACT_SUBMITTED) begin
					entry_mode_q <= 1'b0;
					cnt_q        <= '0;
					for (int s = 0; s < PinLength; s++) begin
						buf_q[s] <= kpe_pkg::EMPTY_SLOT;
					end
				end else begin
					if (!blocked_q) begin
						entry_mode_q <= 1'b1;
					end
					cnt_q <= cnt_n;
					for (int s = 0; s < PinLength; s++) begin
						buf_q[s] <= buf_n[s];
					end
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload, loaded only on emit
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			key_index          <= key_q;
			action             <= act;
			entered_entry_mode <= entered;
			pin_digits         <= pin;
			digit_count        <= (cnt_x > 4'd7) ? 3'd7 : cnt_x[2:0];
			beep_count         <= beeps;
			last_of_scan       <= (later == '0);
		end
	end

	assign out_valid = out_valid_q;

endmodule
